// ===== rtl/sdik_pkg.sv =====
// Package for the swerve drive inverse kinematics block.
// Widths, fixed-point constants, pipeline stage indexes and small helpers.
// No dependencies.
package sdik_pkg;

  // Wheel order: front left, front right, rear left, rear right
  localparam int NW = 4;

  // Field widths
  localparam int FW      = 16;            // every input / output field
  localparam int IN_W    = 7 * FW;        // packed input item
  localparam int OUT_W   = 8 * FW;        // packed result item
  localparam int CFG_IW  = 3;             // register index
  localparam int SPDL_W  = 15;            // wheel speed limit register

  // Datapath widths
  localparam int P1W     = 33;            // yaw_rate * radius
  localparam int P2W     = 49;            // times 46341, plus rounding
  localparam int K_SHIFT = 28;
  localparam int KW      = 20;            // k, signed Q.12
  localparam int CW      = 21;            // wheel components, signed Q.12
  localparam int AW      = 20;            // component magnitude
  localparam int SQW     = 40;            // sum of squares / root work
  localparam int MAGW    = 20;            // vector magnitude
  localparam int XYW     = 32;            // rotation x/y, Q.20
  localparam int ZW      = 20;            // rotation angle, Q.16
  localparam int RAWW    = 17;            // raw angle, Q.12
  localparam int TGW     = 19;            // angle target math
  localparam int SPDW    = 20;            // raw speed, 0.1 rpm
  localparam int NUMW    = 37;            // divider numerator
  localparam int DENW    = 21;            // divider denominator
  localparam int QW      = 16;            // divider quotient
  localparam int SSW     = 22;            // signed speed before saturation
  localparam int SATW    = 24;            // saturation input

  // Step counts
  localparam int ISQ_STEPS    = 20;
  localparam int CORDIC_STEPS = 16;
  localparam int DIV_STEPS    = 16;

  // Pipeline stage indexes (valid bit positions)
  localparam int ST_LOOP0 = 3;                       // root / rotation loop input
  localparam int ST_SPD   = ST_LOOP0 + ISQ_STEPS + 1; // raw speed and angle
  localparam int ST_FLIP  = ST_SPD + 1;              // limit check and flip
  localparam int ST_DIV0  = ST_FLIP + 1;             // divider input
  localparam int ST_OUT   = ST_DIV0 + DIV_STEPS + 1; // result register
  localparam int NST      = ST_OUT + 1;

  // Fixed-point constants
  localparam logic signed [P2W-1:0]  DIAG_Q16   = 49'sd46341;
  localparam logic signed [P2W-1:0]  K_ROUND    = 49'sd134217728;
  localparam logic signed [ZW-1:0]   HALF_PI_Q16 = 20'sd102944;
  localparam logic signed [TGW-1:0]  PI_Q12     = 19'sd12868;
  localparam logic signed [TGW-1:0]  FLIP_LIMIT = 19'sd6516;

  localparam logic signed [ZW-1:0] ATAN_Q16 [CORDIC_STEPS] = '{
    20'sd51472, 20'sd30385, 20'sd16055, 20'sd8150, 20'sd4091, 20'sd2047,
    20'sd1024,  20'sd512,   20'sd256,   20'sd128,  20'sd64,   20'sd32,
    20'sd16,    20'sd8,     20'sd4,     20'sd2
  };

  // Sign pattern of k per wheel (bit set: subtract k)
  localparam logic [NW-1:0] Y_NEG = 4'b1100;
  localparam logic [NW-1:0] X_NEG = 4'b0101;

  // Register reset values
  localparam logic [FW-1:0]     RADIUS_RST = 16'd2048;
  localparam logic [FW-1:0]     RPM_RST    = 16'd30720;
  localparam logic [SPDL_W-1:0] MAXSPD_RST = 15'd10000;

  typedef enum logic [CFG_IW-1:0] {
    CFG_RADIUS  = 3'd0,
    CFG_RPM     = 3'd1,
    CFG_MAXSPD  = 3'd2,
    CFG_OFF_FL  = 3'd3,
    CFG_OFF_FR  = 3'd4,
    CFG_OFF_RL  = 3'd5,
    CFG_OFF_RR  = 3'd6
  } cfg_idx_e;

  // Clamp to the signed 16 bit range
  function automatic logic signed [FW-1:0] sat16(input logic signed [SATW-1:0] v);
    logic signed [FW-1:0] r;
    if (v > 24'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -24'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[FW-1:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/swerve_drive_inverse_kinematics.sv =====
// Top level of the swerve drive inverse kinematics block.
// Pipelined datapath, register file and output buffer; uses sdik_pkg.
//
// One chassis command (vel_x, vel_y, yaw_rate plus the four measured steering
// positions) enters per cycle while the output buffer has room and yields one
// result with four steering targets and four wheel speeds, which enters a
// two-entry output buffer; the pipeline depth is set by the 20-step square
// root (run side by side with the 16-step angle rotation) and the 16-step
// proportional scaling divider, one step per stage.
// The output buffer decouples the two sides, so input is still taken while one
// result waits; input stalls only once the buffer holds two results. The
// configuration channel is always ready and its registers should be written
// only while no command is in flight. Indexes beyond the register list are
// ignored, as are data bits above a register's width.
module swerve_drive_inverse_kinematics
  import sdik_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // input item: vel_x, vel_y, yaw_rate, fl/fr/rl/rr_steer_pos (lowest first)
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [IN_W-1:0]   s_axis_tdata,
  // result: front left, front right, rear left, rear right steering targets,
  // then the four wheel speeds in the same wheel order (lowest first)
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [OUT_W-1:0]  m_axis_tdata,
  // configuration writes
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [CFG_IW-1:0] cfg_index_i,
  input  logic [FW-1:0]     cfg_data_i
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic        [FW-1:0]     radius_q;
  logic        [FW-1:0]     rpm_q;
  logic        [SPDL_W-1:0] lim_q;
  logic signed [FW-1:0]     off_q [NW];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RADIUS_RST;
      rpm_q    <= RPM_RST;
      lim_q    <= MAXSPD_RST;
      for (int w = 0; w < NW; w++) begin
        off_q[w] <= '0;
      end
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_RADIUS: radius_q  <= cfg_data_i;
        CFG_RPM:    rpm_q     <= cfg_data_i;
        CFG_MAXSPD: lim_q     <= cfg_data_i[SPDL_W-1:0];
        CFG_OFF_FL: off_q[0]  <= cfg_data_i;
        CFG_OFF_FR: off_q[1]  <= cfg_data_i;
        CFG_OFF_RL: off_q[2]  <= cfg_data_i;
        CFG_OFF_RR: off_q[3]  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline control: advance while the output buffer has room
  // ---------------------------------------------------------------------------
  logic [1:0]     cnt_q;
  logic           en;
  logic [NST-1:0] vld_q;

  assign en            = (cnt_q != 2'd2);
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NST-2:0], s_axis_tvalid};
    end
  end

  // ---------------------------------------------------------------------------
  // Measured positions travel alongside until the flip check
  // ---------------------------------------------------------------------------
  logic [4*FW-1:0] pos_q [ST_SPD+1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      pos_q[0] <= s_axis_tdata[IN_W-1:3*FW];
      for (int i = 1; i <= ST_SPD; i++) begin
        pos_q[i] <= pos_q[i-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stages 1-2: k = round(yaw_rate * radius * 0.707107)
  // ---------------------------------------------------------------------------
  logic signed [P1W-1:0] p1_q;
  logic signed [P2W-1:0] p2_q;
  logic signed [FW-1:0]  vx1_q, vy1_q, vx2_q, vy2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_q  <= $signed(s_axis_tdata[3*FW-1:2*FW]) * $signed({1'b0, radius_q});
      vx1_q <= s_axis_tdata[FW-1:0];
      vy1_q <= s_axis_tdata[2*FW-1:FW];
      p2_q  <= P2W'(p1_q) * DIAG_Q16 + K_ROUND;
      vx2_q <= vx1_q;
      vy2_q <= vy1_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: per-wheel components
  // ---------------------------------------------------------------------------
  logic signed [KW-1:0] k_s;
  logic signed [CW-1:0] yc_q [NW];
  logic signed [CW-1:0] xc_q [NW];

  assign k_s = $signed(p2_q[KW+K_SHIFT-1:K_SHIFT]);

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int w = 0; w < NW; w++) begin
        yc_q[w] <= CW'(vy2_q) + (Y_NEG[w] ? -CW'(k_s) : CW'(k_s));
        xc_q[w] <= CW'(vx2_q) + (X_NEG[w] ? -CW'(k_s) : CW'(k_s));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: sum of squares and rotation pre-step into the right half plane
  // ---------------------------------------------------------------------------
  logic        [SQW-1:0] iv_q [ISQ_STEPS+1][NW];
  logic        [SQW-1:0] ir_q [ISQ_STEPS+1][NW];
  logic signed [XYW-1:0] cx_q [ISQ_STEPS+1][NW];
  logic signed [XYW-1:0] cy_q [ISQ_STEPS+1][NW];
  logic signed [ZW-1:0]  cz_q [ISQ_STEPS+1][NW];

  for (genvar w = 0; w < NW; w++) begin : g_pre
    logic        [AW-1:0]  ay, ax;
    logic signed [XYW-1:0] xs, ys, x0, y0;
    logic signed [ZW-1:0]  z0;

    always_comb begin
      ay = (yc_q[w] < 0) ? AW'(-yc_q[w]) : AW'(yc_q[w]);
      ax = (xc_q[w] < 0) ? AW'(-xc_q[w]) : AW'(xc_q[w]);
      xs = XYW'(xc_q[w]) <<< 8;
      ys = XYW'(yc_q[w]) <<< 8;
      x0 = xs;
      y0 = ys;
      z0 = '0;
      if (xc_q[w] < 0) begin
        if (yc_q[w] >= 0) begin
          x0 = ys;
          y0 = -xs;
          z0 = HALF_PI_Q16;
        end else begin
          x0 = -ys;
          y0 = xs;
          z0 = -HALF_PI_Q16;
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        iv_q[0][w] <= SQW'(ay) * SQW'(ay) + SQW'(ax) * SQW'(ax);
        ir_q[0][w] <= '0;
        cx_q[0][w] <= x0;
        cy_q[0][w] <= y0;
        cz_q[0][w] <= z0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Square root and angle rotation, one step per stage
  // ---------------------------------------------------------------------------
  for (genvar j = 0; j < ISQ_STEPS; j++) begin : g_loop
    localparam logic [SQW-1:0] BIT = SQW'(1) << (2 * (ISQ_STEPS - 1 - j));
    for (genvar w = 0; w < NW; w++) begin : g_wh
      logic        [SQW-1:0] t, v_d, r_d;
      logic signed [XYW-1:0] x_d, y_d;
      logic signed [ZW-1:0]  z_d;

      always_comb begin
        // root bit
        t = ir_q[j][w] + BIT;
        if (iv_q[j][w] >= t) begin
          v_d = iv_q[j][w] - t;
          r_d = (ir_q[j][w] >> 1) + BIT;
        end else begin
          v_d = iv_q[j][w];
          r_d = ir_q[j][w] >> 1;
        end
        // rotation step, hold once y reaches zero
        x_d = cx_q[j][w];
        y_d = cy_q[j][w];
        z_d = cz_q[j][w];
        if (j < CORDIC_STEPS) begin
          if (cy_q[j][w] > 0) begin
            x_d = cx_q[j][w] + (cy_q[j][w] >>> j);
            y_d = cy_q[j][w] - (cx_q[j][w] >>> j);
            z_d = cz_q[j][w] + ATAN_Q16[j % CORDIC_STEPS];
          end else if (cy_q[j][w] < 0) begin
            x_d = cx_q[j][w] - (cy_q[j][w] >>> j);
            y_d = cy_q[j][w] + (cx_q[j][w] >>> j);
            z_d = cz_q[j][w] - ATAN_Q16[j % CORDIC_STEPS];
          end
        end
      end

      always_ff @(posedge clk_i) begin
        if (en) begin
          iv_q[j+1][w] <= v_d;
          ir_q[j+1][w] <= r_d;
          cx_q[j+1][w] <= x_d;
          cy_q[j+1][w] <= y_d;
          cz_q[j+1][w] <= z_d;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Raw speed and angle
  // ---------------------------------------------------------------------------
  logic signed [RAWW-1:0] raw_q [NW];
  logic        [SPDW-1:0] spd_q [NW];

  for (genvar w = 0; w < NW; w++) begin : g_spd
    logic        [MAGW-1:0]  mag;
    logic        [SQW-1:0]   m1, m10;
    logic signed [ZW-1:0]    zr;

    always_comb begin
      mag = ir_q[ISQ_STEPS][w][MAGW-1:0];
      m1  = SQW'(mag) * SQW'(rpm_q);
      m10 = (m1 << 3) + (m1 << 1) + (SQW'(1) << 19);
      zr  = cz_q[ISQ_STEPS][w] + ZW'(8);
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        spd_q[w] <= m10[SPDW+19:20];
        raw_q[w] <= RAWW'(zr >>> 4);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Largest speed, limit check, steering target and flip decision
  // ---------------------------------------------------------------------------
  logic        [SPDW-1:0] mxa, mxb, mx;
  logic        [SPDW-1:0] mx_q;
  logic                   scl_q;
  logic        [SPDW-1:0] sp2_q [NW];
  logic signed [FW-1:0]   ang2_q [NW];
  logic                   flp2_q [NW];

  always_comb begin
    mxa = (spd_q[0] > spd_q[1]) ? spd_q[0] : spd_q[1];
    mxb = (spd_q[2] > spd_q[3]) ? spd_q[2] : spd_q[3];
    mx  = (mxa > mxb) ? mxa : mxb;
  end

  for (genvar w = 0; w < NW; w++) begin : g_flip
    logic signed [TGW-1:0] tgt, d, ad, t2;
    logic                  flip;

    always_comb begin
      tgt  = TGW'(raw_q[w]) + TGW'(off_q[w]);
      d    = tgt - TGW'($signed(pos_q[ST_SPD][FW*w +: FW]));
      ad   = (d < 0) ? -d : d;
      flip = (ad >= FLIP_LIMIT);
      t2   = tgt;
      if (flip) begin
        t2 = (raw_q[w] > 0) ? tgt - PI_Q12 : tgt + PI_Q12;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        sp2_q[w]  <= spd_q[w];
        ang2_q[w] <= sat16(SATW'(t2));
        flp2_q[w] <= flip;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mx_q  <= mx;
      scl_q <= (mx > SPDW'(lim_q));
    end
  end

  // ---------------------------------------------------------------------------
  // Proportional scaling divider: round(speed * limit / max), one bit a stage
  // ---------------------------------------------------------------------------
  logic        [NUMW-1:0] rem_q [DIV_STEPS+1][NW];
  logic        [QW-1:0]   dq_q  [DIV_STEPS+1][NW];
  logic        [SPDW-1:0] dsp_q [DIV_STEPS+1][NW];
  logic signed [FW-1:0]   dang_q[DIV_STEPS+1][NW];
  logic                   dflp_q[DIV_STEPS+1][NW];
  logic        [DENW-1:0] dden_q[DIV_STEPS+1];
  logic                   dscl_q[DIV_STEPS+1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      dden_q[0] <= DENW'(mx_q) << 1;
      dscl_q[0] <= scl_q;
      for (int w = 0; w < NW; w++) begin
        rem_q[0][w]  <= ((NUMW'(sp2_q[w]) * NUMW'(lim_q)) << 1) + NUMW'(mx_q);
        dq_q[0][w]   <= '0;
        dsp_q[0][w]  <= sp2_q[w];
        dang_q[0][w] <= ang2_q[w];
        dflp_q[0][w] <= flp2_q[w];
      end
    end
  end

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    localparam int B = DIV_STEPS - 1 - i;
    for (genvar w = 0; w < NW; w++) begin : g_wh
      logic [NUMW-1:0] dsh;
      logic            take;

      always_comb begin
        dsh  = NUMW'(dden_q[i]) << B;
        take = (rem_q[i][w] >= dsh);
      end

      always_ff @(posedge clk_i) begin
        if (en) begin
          rem_q[i+1][w]  <= take ? rem_q[i][w] - dsh : rem_q[i][w];
          dq_q[i+1][w]   <= dq_q[i][w] | (QW'(take) << B);
          dsp_q[i+1][w]  <= dsp_q[i][w];
          dang_q[i+1][w] <= dang_q[i][w];
          dflp_q[i+1][w] <= dflp_q[i][w];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dden_q[i+1] <= dden_q[i];
        dscl_q[i+1] <= dscl_q[i];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result register: pick scaled speed, apply flip, saturate
  // ---------------------------------------------------------------------------
  logic [OUT_W-1:0] res_d, res_q;

  always_comb begin
    logic        [SPDW-1:0] sel;
    logic signed [SSW-1:0]  sv;
    res_d = '0;
    for (int w = 0; w < NW; w++) begin
      sel = dscl_q[DIV_STEPS] ? SPDW'(dq_q[DIV_STEPS][w]) : dsp_q[DIV_STEPS][w];
      sv  = $signed(SSW'(sel));
      if (dflp_q[DIV_STEPS][w]) begin
        sv = -sv;
      end
      res_d[FW*w +: FW]        = dang_q[DIV_STEPS][w];
      res_d[FW*(w+NW) +: FW]   = sat16(SATW'(sv));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q <= res_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Two-entry output buffer
  // ---------------------------------------------------------------------------
  logic [OUT_W-1:0] sk_q [2];
  logic             push, pop;
  logic [1:0]       wr_idx;

  assign push          = en && vld_q[ST_OUT];
  assign pop           = m_axis_tvalid && m_axis_tready;
  assign wr_idx        = cnt_q - {1'b0, pop};
  assign m_axis_tvalid = (cnt_q != 2'd0);
  assign m_axis_tdata  = sk_q[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  // Write the new result into the first free slot, else shift on a pop
  always_ff @(posedge clk_i) begin
    if (push && wr_idx == 2'd0) begin
      sk_q[0] <= res_q;
    end else if (pop) begin
      sk_q[0] <= sk_q[1];
    end
    if (push && wr_idx == 2'd1) begin
      sk_q[1] <= res_q;
    end
  end

`ifndef SYNTHESIS
  // Buffer never overfills
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("output buffer count out of range");

  // Popping a full buffer presents the second entry next
  a_buf_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && cnt_q == 2'd2) |=> (m_axis_tdata == $past(sk_q[1])))
    else $error("output buffer order broken");

  // Scaled speeds never exceed the limit
  a_div_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[ST_OUT-1] && dscl_q[DIV_STEPS]) |->
      (dq_q[DIV_STEPS][0] <= QW'(lim_q) && dq_q[DIV_STEPS][1] <= QW'(lim_q) &&
       dq_q[DIV_STEPS][2] <= QW'(lim_q) && dq_q[DIV_STEPS][3] <= QW'(lim_q)))
    else $error("scaled speed above limit");
`endif

endmodule

// ===== tb/sv/swerve_drive_inverse_kinematics_chk.sv =====
// Checker for the swerve drive inverse kinematics block.
// Watches the command, result and register channels, computes the expected
// result of each command and compares it; uses sdik_pkg.
module swerve_drive_inverse_kinematics_chk
  import sdik_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  input  logic              s_axis_tready,
  input  logic [IN_W-1:0]   s_axis_tdata,
  input  logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  input  logic [OUT_W-1:0]  m_axis_tdata,
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_o,
  input  logic [CFG_IW-1:0] cfg_index_i,
  input  logic [FW-1:0]     cfg_data_i,
  output int                fail_count_o,
  output int                pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint ATAN_TAB [16] = '{51472, 30385, 16055, 8150, 4091, 2047,
    1024, 512, 256, 128, 64, 32, 16, 8, 4, 2};

  logic [FW-1:0] radius_q, rpm_q, offset_q [4];
  logic [SPDL_W-1:0] limit_q;
  logic [OUT_W-1:0] expected_results [$];

  assign pending_o = expected_results.size();

  // Floor division by a power of two
  function automatic longint floor_shr(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint sx(logic [FW-1:0] v);
    return longint'($signed(v));
  endfunction

  function automatic longint clamp16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic longint int_root(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  // Rotation-based atan2, Q.12 in and out
  function automatic longint steer_angle(longint y, longint x);
    longint z, t, nx, ny;
    z = 0;
    if (x == 0 && y == 0) return 0;
    x *= 256;
    y *= 256;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = 102944;
      end else begin
        x = -y; y = t; z = -102944;
      end
    end
    for (int i = 0; i < 16; i++) begin
      if (y == 0) break;
      if (y > 0) begin
        nx = x + floor_shr(y, i); ny = y - floor_shr(x, i); z += ATAN_TAB[i];
      end else begin
        nx = x - floor_shr(y, i); ny = y + floor_shr(x, i); z -= ATAN_TAB[i];
      end
      x = nx;
      y = ny;
    end
    return floor_shr(z + 8, 4);
  endfunction

  function automatic logic [OUT_W-1:0] wheel_targets(logic [IN_W-1:0] d);
    longint vx, vy, wz, k, yc, xc, m, lim, tgt, delta, off;
    longint raw [4], spd [4];
    logic [OUT_W-1:0] r;
    vx = sx(d[15:0]);
    vy = sx(d[31:16]);
    wz = sx(d[47:32]);
    lim = longint'(limit_q);
    m = 0;
    r = '0;
    k = floor_shr(wz * longint'(radius_q) * 46341 + (64'sd1 <<< 27), 28);
    for (int w = 0; w < 4; w++) begin
      yc = Y_NEG[w] ? vy - k : vy + k;
      xc = X_NEG[w] ? vx - k : vx + k;
      spd[w] = (int_root(yc * yc + xc * xc) * longint'(rpm_q) * 10 + (64'sd1 <<< 19)) >>> 20;
      if (spd[w] > m) m = spd[w];
      raw[w] = steer_angle(yc, xc);
    end
    if (m > lim)
      for (int w = 0; w < 4; w++) spd[w] = (spd[w] * lim * 2 + m) / (2 * m);
    for (int w = 0; w < 4; w++) begin
      off = sx(offset_q[w]);
      tgt = raw[w] + off;
      delta = tgt - sx(d[48 + 16 * w +: 16]);
      if (delta < 0) delta = -delta;
      if (delta >= 6516) begin
        tgt = (raw[w] > 0) ? off - 12868 + raw[w] : off + 12868 + raw[w];
        spd[w] = -spd[w];
      end
      r[16 * w +: 16] = 16'(clamp16(tgt));
      r[64 + 16 * w +: 16] = 16'(clamp16(spd[w]));
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_count_o++;
  endtask

  initial fail_count_o = 0;

  // Track registers, queue predictions and compare results
  always @(posedge clk_i or negedge rst_ni) begin
    logic [OUT_W-1:0] want;
    if (!rst_ni) begin
      radius_q <= RADIUS_RST;
      rpm_q <= RPM_RST;
      limit_q <= MAXSPD_RST;
      for (int w = 0; w < 4; w++) offset_q[w] <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        expected_results.push_back(wheel_targets(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", 0, 0);
        end else begin
          want = expected_results.pop_front();
          for (int f = 0; f < 8; f++)
            if (m_axis_tdata[16 * f +: 16] !== want[16 * f +: 16])
              report_mismatch(f < 4 ? $sformatf("angle_target[%0d]", f)
                                    : $sformatf("wheel_speed[%0d]", f - 4),
                              sx(m_axis_tdata[16 * f +: 16]), sx(want[16 * f +: 16]));
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_RADIUS: radius_q <= cfg_data_i;
          CFG_RPM:    rpm_q <= cfg_data_i;
          CFG_MAXSPD: limit_q <= cfg_data_i[SPDL_W-1:0];
          CFG_OFF_FL: offset_q[0] <= cfg_data_i;
          CFG_OFF_FR: offset_q[1] <= cfg_data_i;
          CFG_OFF_RL: offset_q[2] <= cfg_data_i;
          CFG_OFF_RR: offset_q[3] <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end
endmodule

// ===== tb/sv/swerve_drive_inverse_kinematics_tb.sv =====
// Top of the swerve drive inverse kinematics testbench.
// Drives commands with random gaps, register writes and result back pressure;
// uses sdik_pkg, the block and swerve_drive_inverse_kinematics_chk.
module swerve_drive_inverse_kinematics_tb;
  import sdik_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0, s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid, m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;
  logic cfg_valid_i = 1'b0, cfg_ready_o;
  logic [CFG_IW-1:0] cfg_index_i = '0;
  logic [FW-1:0] cfg_data_i = '0;
  int fail_count, pending;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  swerve_drive_inverse_kinematics i_dut (.*);

  swerve_drive_inverse_kinematics_chk i_chk (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .cfg_valid_i, .cfg_ready_o,
    .cfg_index_i, .cfg_data_i, .fail_count_o(fail_count), .pending_o(pending)
  );

  task automatic write_reg(logic [CFG_IW-1:0] idx, logic [FW-1:0] val);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = val;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Drain results, then let the pipeline settle before touching registers
  task automatic drain();
    while (pending != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
  endtask

  task automatic send_cmd(logic [IN_W-1:0] d);
    int gap;
    gap = $urandom_range(0, 8);
    if ($urandom_range(0, 3) == 0) gap = 0;
    repeat (gap) @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tdata = d;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  function automatic logic [FW-1:0] rand_field();
    case ($urandom_range(0, 5))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'($signed($urandom_range(0, 2000)) - 1000);
      3: return 16'($signed($urandom_range(0, 26000)) - 13000);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [IN_W-1:0] rand_cmd();
    logic [IN_W-1:0] d;
    for (int f = 0; f < 7; f++) d[16 * f +: 16] = rand_field();
    return d;
  endfunction

  function automatic logic [IN_W-1:0] cmd(logic [FW-1:0] vx, logic [FW-1:0] vy,
                                          logic [FW-1:0] wz, logic [FW-1:0] pos);
    return {pos, pos, pos, pos, wz, vy, vx};
  endfunction

  // Receiver back pressure: a random stall after each accepted result
  always begin
    int stall;
    @(negedge clk_i);
    if (m_axis_tvalid && m_axis_tready) begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
      m_axis_tready = 1'b0;
      repeat (stall) @(negedge clk_i);
      m_axis_tready = 1'b1;
    end else begin
      m_axis_tready = 1'b1;
    end
  end

  initial begin
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    // Directed: zero vector, axes, negative X, extremes, saturation
    send_cmd(cmd(16'd0, 16'd0, 16'd0, 16'd0));
    send_cmd(cmd(16'h8000, 16'd0, 16'd0, 16'd0));
    send_cmd(cmd(16'h8000, 16'd0, 16'd0, 16'd12868));
    send_cmd(cmd(16'd4096, 16'd0, 16'd0, 16'd0));
    send_cmd(cmd(16'd0, 16'd4096, 16'd0, 16'd0));
    send_cmd(cmd(16'd0, 16'hf000, 16'd0, 16'd0));
    send_cmd(cmd(16'd0, 16'd0, 16'd4096, 16'd0));
    send_cmd(cmd(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff));
    send_cmd(cmd(16'h8000, 16'h8000, 16'h8000, 16'h8000));
    send_cmd(cmd(16'h7fff, 16'h8000, 16'h7fff, 16'h8000));
    send_cmd(cmd(16'd100, 16'd50, 16'hffce, 16'hf000));
    send_cmd('1);
    drain();
    // Zero limit, huge offsets, large radius and rpm, ignored index
    write_reg(CFG_MAXSPD, 16'hffff);
    write_reg(CFG_MAXSPD, 16'd0);
    write_reg(CFG_RADIUS, 16'hffff);
    write_reg(CFG_RPM, 16'hffff);
    write_reg(CFG_OFF_FL, 16'h7fff);
    write_reg(CFG_OFF_FR, 16'h8000);
    write_reg(CFG_OFF_RL, 16'h4000);
    write_reg(CFG_OFF_RR, 16'hc000);
    write_reg('1, 16'h1234);
    send_cmd(cmd(16'd4096, 16'd0, 16'd0, 16'd0));
    send_cmd(cmd(16'd0, 16'd0, 16'd0, 16'd0));
    send_cmd(cmd(16'h8000, 16'd0, 16'd1000, 16'h7fff));
    send_cmd(cmd(16'h7fff, 16'h7fff, 16'h8000, 16'h8000));
    drain();
    // Random phases, each with fresh register settings
    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: begin
          write_reg(CFG_RADIUS, 16'd0); write_reg(CFG_RPM, 16'd0);
          write_reg(CFG_MAXSPD, 16'h7fff);
        end
        1: begin
          write_reg(CFG_RADIUS, 16'd2048); write_reg(CFG_RPM, 16'd30720);
          write_reg(CFG_MAXSPD, 16'd10000);
          for (int w = 0; w < 4; w++) write_reg(CFG_IW'(CFG_OFF_FL + w), 16'd0);
        end
        default: begin
          write_reg(CFG_RADIUS, 16'($urandom)); write_reg(CFG_RPM, 16'($urandom));
          write_reg(CFG_MAXSPD, 16'($urandom));
          for (int w = 0; w < 4; w++) write_reg(CFG_IW'(CFG_OFF_FL + w), rand_field());
        end
      endcase
      for (int n = 0; n < 75; n++) send_cmd(rand_cmd());
      drain();
    end
    if (fail_count == 0) begin
      $display("swerve_drive_inverse_kinematics verification clean");
    end else begin
      $display("swerve_drive_inverse_kinematics verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2ms;
    $display("swerve_drive_inverse_kinematics verification failed");
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/sdik_pkg.sv
rtl/swerve_drive_inverse_kinematics.sv
tb/sv/swerve_drive_inverse_kinematics_chk.sv
tb/sv/swerve_drive_inverse_kinematics_tb.sv
